// ===== src/mdp_pkg.sv =====
// MIDI byte stream parser: shared types, byte codes and decode helpers.
// No dependencies.
`default_nettype none

package mdp_pkg;

  typedef enum logic [1:0] {
    KIND_SHORT    = 2'd0,
    KIND_REALTIME = 2'd1,
    KIND_SYSEX    = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  localparam logic [7:0] STATUS_MIN    = 8'h80;
  localparam logic [7:0] REALTIME_MIN  = 8'hF8;
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;

  // Program change and channel pressure carry a single data byte.
  function automatic logic one_data_byte(input logic [7:0] status);
    return (status[7:4] == TYPE_PROGRAM) || (status[7:4] == TYPE_PRESSURE);
  endfunction

endpackage

`default_nettype wire

// ===== src/mdp_if.sv =====
// Channel interfaces of the MIDI parser: input bytes and result items.
// Depends on mdp_pkg.
`default_nettype none

interface mdp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [31:0] arrival_time;
  logic        flush;

  modport source (output valid, byte_value, arrival_time, flush, input ready);
  modport sink   (input valid, byte_value, arrival_time, flush, output ready);
endinterface

interface mdp_out_if import mdp_pkg::*;;
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  status_byte;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [7:0]  sysex_byte;
  logic [31:0] stamp;
  logic        last;

  modport source (output valid, kind, status_byte, first_data, second_data, sysex_byte,
                  stamp, last, input ready);
  modport sink   (input valid, kind, status_byte, first_data, second_data, sysex_byte,
                  stamp, last, output ready);
endinterface

`default_nettype wire

// ===== src/midi_byte_stream_parser.sv =====
// MIDI byte stream parser top level: control block plus sysex buffer RAM.
// Depends on mdp_pkg, mdp_if, mdp_ram and mdp_ctrl.
//
//   channel   dir   fields
//   in_if     sink  byte_value[7:0] arrival_time[31:0] flush
//   out_if    src   kind status_byte first_data second_data sysex_byte stamp last
//
// One byte is taken per cycle while the output register is free or being
// drained; a byte that yields a result fills that register directly.
// A terminating F7 starts a read-out of the buffered run: each sysex byte is read
// from the RAM, then put in the output register; input waits until the run ends.
// A stalled output blocks further input. Reset clears all control state; the
// buffer RAM needs no clearing since only entries of the current message are read.
`default_nettype none

module midi_byte_stream_parser import mdp_pkg::*; #(
  parameter int unsigned SYSEX_DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mdp_in_if.sink    in_if,
  mdp_out_if.source out_if
);

  localparam int unsigned ADDR_W = $clog2(SYSEX_DEPTH);
  localparam int unsigned FILL_W = $clog2(SYSEX_DEPTH + 1);

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  mdp_ctrl #(
    .SYSEX_DEPTH (SYSEX_DEPTH),
    .ADDR_W      (ADDR_W),
    .FILL_W      (FILL_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  mdp_ram #(
    .WIDTH  (8),
    .DEPTH  (SYSEX_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_sysex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== src/mdp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/mdp_ctrl.sv =====
// Parser control: message assembly, sysex buffering into the RAM, run read-out
// and the output register. Depends on mdp_pkg and mdp_if.
`default_nettype none

module mdp_ctrl import mdp_pkg::*; #(
  parameter int unsigned SYSEX_DEPTH = 64,
  parameter int unsigned ADDR_W = $clog2(SYSEX_DEPTH),
  parameter int unsigned FILL_W = $clog2(SYSEX_DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  mdp_in_if.sink                 in_if,
  mdp_out_if.source              out_if,
  output      logic              ram_we_o,
  output      logic [ADDR_W-1:0] ram_waddr_o,
  output      logic [7:0]        ram_wdata_o,
  output      logic              ram_re_o,
  output      logic [ADDR_W-1:0] ram_raddr_o,
  input  wire logic [7:0]        ram_rdata_i
);

  typedef enum logic [1:0] {
    PH_IDLE, PH_SHORT, PH_SYSEX, PH_DISCARD
  } phase_e;

  typedef enum logic [1:0] {
    S_ACCEPT, S_RD_ISSUE, S_RD_WAIT
  } state_e;

  state_e            state_q;
  phase_e            phase_q, phase_d;
  logic [7:0]        held_status_q, held_status_d;
  logic [7:0]        held_first_q, held_first_d;
  logic [1:0]        need_q, need_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [ADDR_W-1:0] rd_idx_q, run_end_q;
  logic [31:0]       run_stamp_q;

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [7:0]        out_status_q, out_first_q, out_second_q, out_sysex_q;
  logic [31:0]       out_stamp_q;
  logic              out_last_q;

  logic              out_free, accept, start_run, emit, out_load;
  kind_e             emit_kind;
  logic [7:0]        emit_status, emit_first, emit_second;
  logic [7:0]        b;
  logic              run_last;

  assign out_free     = !out_valid_q || out_if.ready;
  assign in_if.ready  = (state_q == S_ACCEPT) && out_free;
  assign accept       = in_if.valid && in_if.ready;
  assign b            = in_if.byte_value;

  assign ram_wdata_o  = b;
  assign ram_re_o     = (state_q == S_RD_ISSUE) && out_free;
  assign ram_raddr_o  = rd_idx_q;
  assign run_last     = (rd_idx_q == run_end_q);

  // output register gets a new transfer this cycle
  assign out_load     = emit || (state_q == S_RD_WAIT);

  always_comb begin
    phase_d       = phase_q;
    held_status_d = held_status_q;
    held_first_d  = held_first_q;
    need_d        = need_q;
    fill_d        = fill_q;
    emit          = 1'b0;
    emit_kind     = KIND_SHORT;
    emit_status   = '0;
    emit_first    = '0;
    emit_second   = '0;
    ram_we_o      = 1'b0;
    ram_waddr_o   = fill_q[ADDR_W-1:0];
    start_run     = 1'b0;
    if (accept) begin
      if (in_if.flush) begin
        phase_d       = PH_IDLE;
        held_status_d = '0;
        held_first_d  = '0;
        need_d        = '0;
        fill_d        = '0;
      end else if (b >= REALTIME_MIN) begin
        emit        = 1'b1;
        emit_kind   = KIND_REALTIME;
        emit_status = b;
      end else begin
        unique case (phase_q)
          PH_SYSEX: begin
            if (fill_q >= FILL_W'(SYSEX_DEPTH)) begin
              emit      = 1'b1;
              emit_kind = KIND_OVERFLOW;
              fill_d    = '0;
              phase_d   = (b == SYSEX_END) ? PH_IDLE : PH_DISCARD;
            end else begin
              ram_we_o = 1'b1;
              fill_d   = fill_q + 1'b1;
              if (b == SYSEX_END) begin
                start_run = 1'b1;
                fill_d    = '0;
                phase_d   = PH_IDLE;
              end
            end
          end
          PH_DISCARD: begin
            if (b == SYSEX_END) begin
              phase_d = PH_IDLE;
            end
          end
          PH_IDLE, PH_SHORT: begin
            if (b >= STATUS_MIN) begin
              if (b == SYSEX_START) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = '0;
                fill_d      = FILL_W'(1);
                phase_d     = PH_SYSEX;
                need_d      = '0;
              end else begin
                held_status_d = b;
                held_first_d  = '0;
                need_d        = one_data_byte(b) ? 2'd1 : 2'd2;
                phase_d       = PH_SHORT;
              end
            end else if (phase_q == PH_SHORT) begin
              if (need_q == 2'd2) begin
                held_first_d = b;
                need_d       = 2'd1;
              end else begin
                emit        = 1'b1;
                emit_kind   = KIND_SHORT;
                emit_status = held_status_q;
                if (one_data_byte(held_status_q)) begin
                  emit_first = b;
                end else begin
                  emit_first  = held_first_q;
                  emit_second = b;
                end
                phase_d      = PH_IDLE;
                need_d       = '0;
                held_first_d = '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_ACCEPT;
      phase_q       <= PH_IDLE;
      held_status_q <= '0;
      held_first_q  <= '0;
      need_q        <= '0;
      fill_q        <= '0;
      rd_idx_q      <= '0;
      run_end_q     <= '0;
      run_stamp_q   <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= KIND_SHORT;
      out_status_q  <= '0;
      out_first_q   <= '0;
      out_second_q  <= '0;
      out_sysex_q   <= '0;
      out_stamp_q   <= '0;
      out_last_q    <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      held_status_q <= held_status_d;
      held_first_q  <= held_first_d;
      need_q        <= need_d;
      fill_q        <= fill_d;

      if (out_valid_q && out_if.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_ACCEPT: begin
          if (emit) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= emit_kind;
            out_status_q <= emit_status;
            out_first_q  <= emit_first;
            out_second_q <= emit_second;
            out_sysex_q  <= '0;
            out_stamp_q  <= in_if.arrival_time;
            out_last_q   <= 1'b1;
          end
          if (start_run) begin
            // F7 lands at index fill; run covers entries 0..fill
            rd_idx_q    <= '0;
            run_end_q   <= fill_q[ADDR_W-1:0];
            run_stamp_q <= in_if.arrival_time;
            state_q     <= S_RD_ISSUE;
          end
        end
        S_RD_ISSUE: begin
          if (ram_re_o) begin
            state_q <= S_RD_WAIT;
          end
        end
        S_RD_WAIT: begin
          // output slot was freed when the read was issued
          out_valid_q  <= 1'b1;
          out_kind_q   <= KIND_SYSEX;
          out_status_q <= '0;
          out_first_q  <= '0;
          out_second_q <= '0;
          out_sysex_q  <= ram_rdata_i;
          out_stamp_q  <= run_stamp_q;
          out_last_q   <= run_last;
          if (run_last) begin
            state_q <= S_ACCEPT;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
            state_q  <= S_RD_ISSUE;
          end
        end
        default: state_q <= S_ACCEPT;
      endcase
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.kind        = out_kind_q;
  assign out_if.status_byte = out_status_q;
  assign out_if.first_data  = out_first_q;
  assign out_if.second_data = out_second_q;
  assign out_if.sysex_byte  = out_sysex_q;
  assign out_if.stamp       = out_stamp_q;
  assign out_if.last        = out_last_q;

endmodule

`default_nettype wire
